### hw/rtl/xorshift1024_star_random_source_core_defines.svh
// ----------------------------------------------------------------------------
// xorshift1024* random source: assertion macros
// Clocked assertion wrappers used by the core of the random source.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT1024_STAR_RANDOM_SOURCE_CORE_DEFINES_SVH
`define XORSHIFT1024_STAR_RANDOM_SOURCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define XRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define XRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XRS_ASSERT(lbl, prop, msg)
`define XRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/xrs_pkg.sv
// ----------------------------------------------------------------------------
// xrs_pkg
// Constants and types shared by the xorshift1024* random source.
// ----------------------------------------------------------------------------
package xrs_pkg;

	// word sizes
	localparam int WORD_W     = 64;
	localparam int HALF_W     = 32;
	localparam int DATA_W     = 32;
	localparam int POOL_DEPTH = 16;
	localparam int POOL_AW    = 4;
	localparam int DIV_CNT_W  = 5;

	// request kinds carried on the mode field
	localparam logic MODE_RESEED = 1'b0;
	localparam logic MODE_DRAW   = 1'b1;

	// seeder (xorshift64*) constants
	localparam logic [WORD_W-1:0] SEED_RESET = 64'h05a3_ae52_de3b_bf0a;
	localparam logic [WORD_W-1:0] SEED_MUL   = 64'd2685821657736338717;
	localparam int SEED_SH_A = 12;
	localparam int SEED_SH_B = 25;
	localparam int SEED_SH_C = 27;

	// generator (xorshift1024*) constants
	localparam logic [WORD_W-1:0] GEN_MUL = 64'd1181783497276652981;
	localparam int GEN_SH_A = 31;
	localparam int GEN_SH_B = 11;
	localparam int GEN_SH_C = 30;

	// status of the modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} xrs_div_stat_t;

endpackage

### hw/rtl/xrs_ram.sv
// ----------------------------------------------------------------------------
// xrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/xrs_mod.sv
// ----------------------------------------------------------------------------
// xrs_mod
// Restoring 32-bit modulo unit, one remainder bit per cycle.
// ----------------------------------------------------------------------------
module xrs_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [xrs_pkg::DATA_W-1:0]  dividend,
	input  logic [xrs_pkg::DATA_W-1:0]  divisor,
	output xrs_pkg::xrs_div_stat_t      stat,
	output logic [xrs_pkg::DATA_W-1:0]  rem
);
	import xrs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    dvd_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic                 fits;

	// one restoring step: shift in the next dividend bit, subtract when it fits
	assign shifted = {rem_q, dvd_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = (shifted >= {1'b0, dsr_q});

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

### hw/rtl/xorshift1024_star_random_source_core.sv
// ----------------------------------------------------------------------------
// xorshift1024_star_random_source_core
// xorshift1024* random source with a xorshift64* seeder and modulo reduction.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit first)
// s_axis    in   tuser: mode[0]; tdata: range[31:0]
// m_axis    out  tdata: value[31:0]
//
// a reseed fills each pool word: seeder shift, three multiplier products, write
// a draw mixes two pool words, multiplies, then waits on the bit-serial modulo unit
// a draw with range zero or all ones skips the modulo unit
// reset empties the pool (reads as zero) at once; no clearing pass is needed
// one item is worked at a time; the next is taken while a result waits on m_axis
`include "xorshift1024_star_random_source_core_defines.svh"

module xorshift1024_star_random_source_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [xrs_pkg::DATA_W-1:0]  s_axis_tdata,   // range[31:0]
	input  logic                        s_axis_tuser,   // mode[0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [xrs_pkg::DATA_W-1:0]  m_axis_tdata    // value[31:0]
);
	import xrs_pkg::*;

	// sequencer states
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [ST_W-1:0] ST_SEED_SH  = 4'd1;
	localparam logic [ST_W-1:0] ST_SEED_M0  = 4'd2;
	localparam logic [ST_W-1:0] ST_SEED_M1  = 4'd3;
	localparam logic [ST_W-1:0] ST_SEED_M2  = 4'd4;
	localparam logic [ST_W-1:0] ST_SEED_WR  = 4'd5;
	localparam logic [ST_W-1:0] ST_DRAW_RA  = 4'd6;
	localparam logic [ST_W-1:0] ST_DRAW_RB  = 4'd7;
	localparam logic [ST_W-1:0] ST_DRAW_MIX = 4'd8;
	localparam logic [ST_W-1:0] ST_DRAW_MUL = 4'd9;
	localparam logic [ST_W-1:0] ST_DRAW_RED = 4'd10;
	localparam logic [ST_W-1:0] ST_DRAW_DIV = 4'd11;
	localparam logic [ST_W-1:0] ST_DONE     = 4'd12;

	logic [ST_W-1:0]       state_q, state_d;
	logic [POOL_AW-1:0]    pos_q;
	logic [POOL_AW-1:0]    pos_nxt;
	logic [POOL_AW-1:0]    seed_idx_q;
	logic [WORD_W-1:0]     seed_q;
	logic [POOL_DEPTH-1:0] pool_vld_q;
	logic                  m_tvalid_q;
	logic [DATA_W-1:0]     m_tdata_q;

	logic                  mode_q;
	logic [DATA_W-1:0]     range_q;
	logic [WORD_W-1:0]     a_q;
	logic [WORD_W-1:0]     mix_q;
	logic [WORD_W-1:0]     acc_q;
	logic [DATA_W-1:0]     res_q;
	logic                  rd_vld_q;
	logic [2*HALF_W-1:0]   mul_p_q;

	logic                  in_xact;
	logic                  out_load;
	logic [HALF_W-1:0]     mul_a, mul_b;
	logic [POOL_AW-1:0]    rd_addr;
	logic [WORD_W-1:0]     ram_rdata;
	logic [WORD_W-1:0]     rd_word;
	logic                  ram_we;
	logic [POOL_AW-1:0]    ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_W-1:0]     seed_w1, seed_w2, seed_w3;
	logic [WORD_W-1:0]     b1, b2, a1, mix_w;
	logic [HALF_W-1:0]     seed_hi;
	logic                  div_start;
	xrs_div_stat_t         div_stat;
	logic [DATA_W-1:0]     div_rem;

	assign in_xact  = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_axis_tready);
	assign pos_nxt  = pos_q + POOL_AW'(1);

	// seeder xorshift step
	assign seed_w1 = seed_q ^ (seed_q >> SEED_SH_A);
	assign seed_w2 = seed_w1 ^ (seed_w1 << SEED_SH_B);
	assign seed_w3 = seed_w2 ^ (seed_w2 >> SEED_SH_C);

	// pool read: entries never written read as zero
	assign rd_addr = (state_q == ST_DRAW_RA) ? pos_q : pos_nxt;
	assign rd_word = rd_vld_q ? ram_rdata : '0;

	// generator mix of the two pool words
	assign b1    = rd_word ^ (rd_word << GEN_SH_A);
	assign b2    = b1 ^ (b1 >> GEN_SH_B);
	assign a1    = a_q ^ (a_q >> GEN_SH_C);
	assign mix_w = a1 ^ b2;

	// upper half of the seeder product from the three partial products
	assign seed_hi = acc_q[WORD_W-1:HALF_W] + mul_p_q[HALF_W-1:0];

	// pool write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_nxt;
		ram_wdata = mix_w;
		if (state_q == ST_SEED_WR) begin
			ram_we    = 1'b1;
			ram_waddr = seed_idx_q;
			ram_wdata = {seed_hi, acc_q[HALF_W-1:0]};
		end else if (state_q == ST_DRAW_MIX) begin
			ram_we = 1'b1;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SEED_M0: begin
				mul_a = seed_q[HALF_W-1:0];
				mul_b = SEED_MUL[HALF_W-1:0];
			end
			ST_SEED_M1: begin
				mul_a = seed_q[HALF_W-1:0];
				mul_b = SEED_MUL[WORD_W-1:HALF_W];
			end
			ST_SEED_M2: begin
				mul_a = seed_q[WORD_W-1:HALF_W];
				mul_b = SEED_MUL[HALF_W-1:0];
			end
			ST_DRAW_MUL: begin
				mul_a = mix_q[HALF_W-1:0];
				mul_b = GEN_MUL[HALF_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared 32x32 multiplier, registered product
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					if (s_axis_tuser == MODE_RESEED) begin
						state_d = ST_SEED_SH;
					end else if (s_axis_tdata == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_DRAW_RA;
					end
				end
			end
			ST_SEED_SH:  state_d = ST_SEED_M0;
			ST_SEED_M0:  state_d = ST_SEED_M1;
			ST_SEED_M1:  state_d = ST_SEED_M2;
			ST_SEED_M2:  state_d = ST_SEED_WR;
			ST_SEED_WR: begin
				state_d = (seed_idx_q == POOL_AW'(POOL_DEPTH - 1)) ? ST_DONE : ST_SEED_SH;
			end
			ST_DRAW_RA:  state_d = ST_DRAW_RB;
			ST_DRAW_RB:  state_d = ST_DRAW_MIX;
			ST_DRAW_MIX: state_d = ST_DRAW_MUL;
			ST_DRAW_MUL: state_d = ST_DRAW_RED;
			ST_DRAW_RED: begin
				if (range_q == '1) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DRAW_DIV;
				end
			end
			ST_DRAW_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			seed_idx_q <= '0;
			seed_q     <= SEED_RESET;
			pool_vld_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xact) begin
				seed_idx_q <= '0;
			end else if (state_q == ST_SEED_WR) begin
				seed_idx_q <= seed_idx_q + POOL_AW'(1);
			end
			if (state_q == ST_SEED_SH) begin
				seed_q <= seed_w3;
			end
			if (state_q == ST_DRAW_MIX) begin
				pos_q <= pos_nxt;
			end
			if (ram_we) begin
				pool_vld_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_vld_q <= pool_vld_q[rd_addr];
		if (in_xact) begin
			mode_q  <= s_axis_tuser;
			range_q <= s_axis_tdata;
			res_q   <= (s_axis_tuser == MODE_DRAW) ? DATA_W'(1) : '0;
		end
		if (state_q == ST_SEED_M1) begin
			acc_q <= mul_p_q;
		end
		if (state_q == ST_SEED_M2) begin
			acc_q[WORD_W-1:HALF_W] <= seed_hi;
		end
		if (state_q == ST_DRAW_RB) begin
			a_q <= rd_word;
		end
		if (state_q == ST_DRAW_MIX) begin
			mix_q <= mix_w;
		end
		if (state_q == ST_DRAW_RED && range_q == '1) begin
			res_q <= mul_p_q[DATA_W-1:0];
		end
		if (state_q == ST_DRAW_DIV && div_stat.done) begin
			res_q <= div_rem;
		end
		if (out_load) begin
			m_tdata_q <= res_q;
		end
	end

	// pool storage
	xrs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(POOL_DEPTH)
	) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// modulo reduction
	xrs_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mul_p_q[DATA_W-1:0]),
		.divisor (range_q),
		.stat    (div_stat),
		.rem     (div_rem)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// checks
	`XRS_ASSERT(a_div_no_restart, div_start |-> !div_stat.busy, "modulo restarted while busy")
	`XRS_ASSERT(a_rem_below_range, div_stat.done |-> (div_rem < range_q), "remainder too large")
	`XRS_ASSERT(a_pos_hold, (state_q != ST_DRAW_MIX) |=> (pos_q == $past(pos_q)), "position moved")
	`XRS_ASSERT(a_reseed_zero, (out_load && mode_q == MODE_RESEED) |-> (res_q == '0), "reseed not zero")
	`XRS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!m_axis_tvalid && state_q == ST_IDLE), "not idle in reset")

endmodule
